### hw/rtl/lrupc_pkg.sv
// ----------------------------------------------------------------------------
// lrupc_pkg
// Shared types and constants for the LRU replacer with pin counts.
// ----------------------------------------------------------------------------
package lrupc_pkg;

  localparam int ENTRIES   = 16;
  localparam int PIN_BITS  = 8;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int RANK_W    = IDX_W;
  localparam int PAGE_W    = 32;
  localparam int QDEPTH    = 2;

  localparam logic [2:0] FN_TRACK  = 3'd0;
  localparam logic [2:0] FN_FORGET = 3'd1;
  localparam logic [2:0] FN_PIN    = 3'd2;
  localparam logic [2:0] FN_UNPIN  = 3'd3;
  localparam logic [2:0] FN_VICTIM = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  // One classified request handed from front to back.
  typedef struct packed {
    logic [2:0]        func;
    logic [PAGE_W-1:0] page;
    logic              known;
  } req_t;

endpackage

### hw/rtl/lrupc_front.sv
// ----------------------------------------------------------------------------
// lrupc_front
// Accepts requests, classifies the operation and queues them for the engine.
// ----------------------------------------------------------------------------
module lrupc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_func,
  input  logic [lrupc_pkg::PAGE_W-1:0] in_page_id,
  output logic                     q_valid,
  input  logic                     q_pop,
  output lrupc_pkg::req_t          q_data
);
  import lrupc_pkg::*;

  localparam int QP_W = $clog2(QDEPTH);

  req_t              buf_r [QDEPTH];
  logic [QP_W-1:0]   wp_r, rp_r;
  logic [QP_W:0]     cnt_r;
  logic              push;

  assign in_stall = (cnt_r == (QP_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = buf_r[rp_r];

  // Store request and mark whether the code is a real operation
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r].func  <= in_func;
      buf_r[wp_r].page  <= in_page_id;
      buf_r[wp_r].known <= (in_func <= FN_VICTIM);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QP_W+1)'(push) - (QP_W+1)'(q_pop);
    end
  end

endmodule

### hw/rtl/lrupc_engine.sv
// ----------------------------------------------------------------------------
// lrupc_engine
// Walks the entry table one slot a cycle, then applies the update,
// registers the result word and sweeps the recency ranks.
// ----------------------------------------------------------------------------
module lrupc_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  lrupc_pkg::req_t              q_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrupc_pkg::PAGE_W-1:0] out_victim_page,
  output logic                         out_victim_found,
  output logic [1:0]                   out_status
);
  import lrupc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_ADJ  = 2'd3;

  logic [1:0]          state_r;
  logic [IDX_W-1:0]    idx_r;
  req_t                req_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [PAGE_W-1:0]   page_r [ENTRIES];
  logic [PIN_BITS-1:0] pins_r [ENTRIES];
  logic [RANK_W-1:0]   rank_r [ENTRIES];

  logic                hit_r, free_r, vf_r;
  logic [IDX_W-1:0]    hidx_r, fidx_r;
  logic [RANK_W-1:0]   hrank_r, vrank_r;
  logic [PIN_BITS-1:0] hpins_r;
  logic [PAGE_W-1:0]   vpage_r;
  logic [1:0]          adj_r;   // 0 none, 1 age all, 2 dec ranks above dropped, 3 pin move
  localparam logic [1:0] A_NONE = 2'd0, A_AGE = 2'd1, A_DROP = 2'd2, A_MOVE = 2'd3;

  logic                ov_r;
  logic [PAGE_W-1:0]   ovp_r;
  logic                ovf_r;
  logic [1:0]          ost_r;

  logic last;
  logic cur_v, cur_match, cur_cand;
  assign last      = (idx_r == IDX_W'(ENTRIES-1));
  assign cur_v     = valid_r[idx_r];
  assign cur_match = cur_v && (page_r[idx_r] == req_r.page);
  assign cur_cand  = cur_v && (pins_r[idx_r] == '0) && (!vf_r || rank_r[idx_r] > vrank_r);

  assign q_pop            = (state_r == S_IDLE) && q_valid;
  assign out_valid        = ov_r;
  assign out_victim_page  = ovp_r;
  assign out_victim_found = ovf_r;
  assign out_status       = ost_r;

  // Sequence: scan table, decide, then sweep rank updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (ov_r && !out_stall && state_r != S_APPLY) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r   <= q_data;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            vf_r    <= 1'b0;
            vpage_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur_match && !hit_r) begin
            hit_r   <= 1'b1;
            hidx_r  <= idx_r;
            hrank_r <= rank_r[idx_r];
            hpins_r <= pins_r[idx_r];
          end
          if (!cur_v && !free_r) begin
            free_r <= 1'b1;
            fidx_r <= idx_r;
          end
          if (cur_cand) begin
            vf_r    <= 1'b1;
            vrank_r <= rank_r[idx_r];
            vpage_r <= page_r[idx_r];
          end
          idx_r <= idx_r + 1'b1;
          if (last) state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (!ov_r || !out_stall) begin
            ov_r  <= 1'b1;
            ovp_r <= '0;
            ovf_r <= 1'b0;
            ost_r <= ST_OK;
            adj_r <= A_NONE;
            case (req_r.known ? req_r.func : 3'd7)
              FN_TRACK: begin
                if (!hit_r) begin
                  if (!free_r) ost_r <= ST_FULL;
                  else adj_r <= A_AGE;
                end
              end
              FN_FORGET: begin
                if (!hit_r) ost_r <= ST_UNKNOWN;
                else begin
                  valid_r[hidx_r] <= 1'b0;
                  adj_r <= A_DROP;
                end
              end
              FN_PIN: begin
                if (!hit_r) ost_r <= ST_UNKNOWN;
                else if (hpins_r == {PIN_BITS{1'b1}}) ost_r <= ST_LIMIT;
                else begin
                  pins_r[hidx_r] <= hpins_r + 1'b1;
                  adj_r <= A_MOVE;
                end
              end
              FN_UNPIN: begin
                if (!hit_r) ost_r <= ST_UNKNOWN;
                else if (hpins_r == '0) ost_r <= ST_LIMIT;
                else pins_r[hidx_r] <= hpins_r - 1'b1;
              end
              FN_VICTIM: begin
                ovp_r <= vpage_r;
                ovf_r <= vf_r;
              end
              default: ;
            endcase
            idx_r   <= '0;
            state_r <= S_ADJ;
          end
        end
        S_ADJ: begin
          // One entry per cycle; new slot written last so it is not aged
          case (adj_r)
            A_AGE: begin
              if (valid_r[idx_r]) rank_r[idx_r] <= rank_r[idx_r] + 1'b1;
            end
            A_DROP: begin
              if (valid_r[idx_r] && rank_r[idx_r] > hrank_r)
                rank_r[idx_r] <= rank_r[idx_r] - 1'b1;
            end
            A_MOVE: begin
              if (idx_r == hidx_r) rank_r[idx_r] <= '0;
              else if (valid_r[idx_r] && rank_r[idx_r] < hrank_r)
                rank_r[idx_r] <= rank_r[idx_r] + 1'b1;
            end
            default: ;
          endcase
          idx_r <= idx_r + 1'b1;
          if (adj_r == A_NONE || last) begin
            if (adj_r == A_AGE) begin
              valid_r[fidx_r] <= 1'b1;
              page_r[fidx_r]  <= req_r.page;
              pins_r[fidx_r]  <= '0;
              rank_r[fidx_r]  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/lru_replacer_with_pin_counts.sv
// ----------------------------------------------------------------------------
// lru_replacer_with_pin_counts
// Top level: request queue in front of the table engine.
// ----------------------------------------------------------------------------
// Each request that changes recency ranks passes through popping the queue,
// scanning the table one slot per cycle to find the page, a free slot and the
// victim, deciding and registering the result word, then sweeping the ranks.
// A request that leaves the ranks alone skips the sweep. The result word is
// registered in the decide step, which waits while an earlier result is
// still stalled. A two-deep request queue and a registered result let both
// sides stall independently. One result is returned for every request, in
// order.
module lru_replacer_with_pin_counts (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_func,
  input  logic [lrupc_pkg::PAGE_W-1:0] in_page_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrupc_pkg::PAGE_W-1:0] out_victim_page,
  output logic                         out_victim_found,
  output logic [1:0]                   out_status
);
  import lrupc_pkg::*;

  logic q_valid, q_pop;
  req_t q_data;

  lrupc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_page_id,
    .q_valid, .q_pop, .q_data
  );

  lrupc_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_victim_page, .out_victim_found, .out_status
  );

endmodule
